// ===== sv/websocket_frame_unmasker_assert.svh =====
// Assertion macros for the unmasker RTL.
`ifndef WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH
`define WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH
`ifndef SYNTH
`define WSU_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("websocket_frame_unmasker: assertion failed");
`define WSU_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("websocket_frame_unmasker: assertion failed");
`else
`define WSU_ASSERT(lbl, clk, rstn, prop)
`define WSU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/wsunmask_pkg.sv =====
`timescale 1ns / 1ps
package wsunmask_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [3:0] OFFSET_SHORT = 4'd2;
	localparam logic [3:0] OFFSET_EXT16 = 4'd4;
	localparam logic [3:0] OFFSET_EXT64 = 4'd10;
	localparam logic [4:0] KEY_BYTES    = 5'd4;

	// One payload byte on its way from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic       last;
	} qentry_t;

	typedef struct packed {
		logic       in_payload;
		logic [3:0] header_position;
	} front_status_t;

endpackage

// ===== sv/wsunmask_front.sv =====
`timescale 1ns / 1ps
module wsunmask_front
	import wsunmask_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] rx_byte
	input  logic          s_tlast,   // end_of_buffer
	input  logic          q_full,
	output logic          q_push,
	output qentry_t       q_entry,
	output front_status_t status
);

	logic [3:0]      header_position_q;
	logic [3:0]      mask_offset_q;
	logic [3:0][7:0] mask_key_q;
	logic [1:0]      key_index_q;
	logic            in_payload_q;

	logic       accept;
	logic [4:0] pos_ext;
	logic [4:0] off_ext;
	logic       in_key;
	logic [1:0] key_slot;
	logic [3:0] new_offset;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && in_payload_q;

	assign q_entry.data = s_tdata;
	assign q_entry.key  = mask_key_q[key_index_q];
	assign q_entry.last = s_tlast;

	assign status.in_payload      = in_payload_q;
	assign status.header_position = header_position_q;

	assign pos_ext  = {1'b0, header_position_q};
	assign off_ext  = {1'b0, mask_offset_q};
	assign in_key   = (pos_ext >= off_ext) && (pos_ext < off_ext + KEY_BYTES);
	assign key_slot = header_position_q[1:0] - mask_offset_q[1:0];

	always_comb begin
		case (s_tdata[6:0])
			LEN_EXT16: new_offset = OFFSET_EXT16;
			LEN_EXT64: new_offset = OFFSET_EXT64;
			default:   new_offset = OFFSET_SHORT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_position_q <= '0;
			mask_offset_q     <= OFFSET_SHORT;
			mask_key_q        <= '0;
			key_index_q       <= '0;
			in_payload_q      <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				// The buffer ends here, in the header or the payload alike.
				header_position_q <= '0;
				mask_offset_q     <= OFFSET_SHORT;
				mask_key_q        <= '0;
				key_index_q       <= '0;
				in_payload_q      <= 1'b0;
			end else if (in_payload_q) begin
				key_index_q <= key_index_q + 2'd1;
			end else begin
				if (header_position_q == 4'd1) begin
					mask_offset_q <= new_offset;
				end else if (in_key) begin
					mask_key_q[key_slot] <= s_tdata;
					if (key_slot == 2'd3) begin
						in_payload_q <= 1'b1;
					end
				end
				header_position_q <= header_position_q + 4'd1;
			end
		end
	end

endmodule

// ===== sv/wsunmask_queue.sv =====
`timescale 1ns / 1ps
module wsunmask_queue
	import wsunmask_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qentry_t push_entry,
	output logic    full,
	output logic    pop_valid,
	output qentry_t pop_entry,
	input  logic    pop,
	output logic [QAW:0] count
);

	qentry_t          mem [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == QDEPTH[QAW:0]);
	assign pop_valid = (count_q != '0);
	assign pop_entry = mem[rd_ptr_q];
	assign count     = count_q;
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/wsunmask_back.sv =====
`timescale 1ns / 1ps
module wsunmask_back
	import wsunmask_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  qentry_t    q_entry,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] payload_byte
	output logic       m_tlast    // payload_last
);

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;

	// The output register refills in the same cycle that its item is taken.
	assign q_pop    = q_valid && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (q_pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			m_tdata_q <= q_entry.data ^ q_entry.key;
			m_tlast_q <= q_entry.last;
		end
	end

endmodule

// ===== sv/websocket_frame_unmasker.sv =====
`timescale 1ns / 1ps
// Unmasks the payload of a received client frame, one byte per item.
// Input stream s_*: one frame byte per item, tlast on the final byte of the buffer.
// Output stream m_*: one unmasked payload byte per item, tlast on the final one.
// The opcode byte, the length byte, any extended length bytes and the four
// mask key bytes produce no output; each payload byte is XORed with the key
// byte selected by its payload index modulo four.
// A payload byte accepted on s_* is written into the queue and then loaded,
// unmasked, into the output register that drives m_*.
// Throughput: one byte per cycle on both sides while m_tready and a non-full queue let it flow.
// The front parser and the output register are parted by a four-entry queue,
// so the input keeps flowing while the receiver stalls until the queue fills;
// s_tready then drops and rises again as soon as an entry drains.
// A buffer that ends inside the header is dropped without any output.
// After tlast on the input the parser is back at the start of a new frame.
// Reset (arst_n low) empties the queue, clears the output valid flag and
// returns the parser to the first header byte.
module websocket_frame_unmasker
	import wsunmask_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       s_tlast,   // end_of_buffer
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] payload_byte
	output logic       m_tlast    // payload_last
);

`include "websocket_frame_unmasker_assert.svh"

	logic          q_full;
	logic          q_push;
	qentry_t       q_push_entry;
	logic          q_valid;
	qentry_t       q_pop_entry;
	logic          q_pop;
	logic [QAW:0]  q_count;
	front_status_t front_status;
	logic          in_accept;
	logic          front_idle;

	assign in_accept  = s_tvalid && s_tready;
	assign front_idle = !front_status.in_payload && (front_status.header_position == 4'd0);

	wsunmask_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_push_entry),
		.status   (front_status)
	);

	wsunmask_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop_valid  (q_valid),
		.pop_entry  (q_pop_entry),
		.pop        (q_pop),
		.count      (q_count)
	);

	wsunmask_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_pop_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`WSU_ASSERT(a_queue_bound, clk, arst_n, q_count <= QDEPTH[QAW:0])
	`WSU_ASSERT(a_header_silent, clk, arst_n, (in_accept && !front_status.in_payload) |-> !q_push)
	`WSU_ASSERT(a_last_restarts, clk, arst_n, (in_accept && s_tlast) |=> front_idle)
	`WSU_ASSERT(a_back_drains, clk, arst_n, (q_valid && (!m_tvalid || m_tready)) |=> m_tvalid)

endmodule
